### rtl/lbkv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lbkv_pkg;

	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 64;
	localparam int VALUE_BITS = 64;
	localparam int IDX_W      = $clog2(ENTRIES);
	localparam int CNT_W      = $clog2(ENTRIES + 1);

	localparam logic [1:0] CMD_SET    = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_LOOKUP = 2'd2;

	localparam logic [4:0] CAPACITY_RESET = 5'd16;

	typedef struct packed {
		logic [1:0]  command;
		logic [63:0] key;
		logic [63:0] new_value;
	} req_t;

	typedef struct packed {
		logic        found;
		logic [63:0] stored_value;
		logic [4:0]  evictions;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_APPLY = 3'b100
	} state_t;

	typedef enum logic [1:0] {
		MODE_HOLD,
		MODE_FRONT,
		MODE_INSERT,
		MODE_REMOVE
	} cell_mode_t;

	typedef struct packed {
		logic                  valid;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
	} cell_data_t;

	typedef struct packed {
		logic                  pfx;
		logic [VALUE_BITS-1:0] pass;
	} cell_wave_t;

	typedef struct packed {
		cell_mode_t            mode;
		logic                  clr;
		logic                  scan;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
		logic [CNT_W-1:0]      new_count;
	} cell_ctrl_t;

endpackage
`default_nettype wire

### rtl/lbkv_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module lbkv_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [lbkv_pkg::IDX_W-1:0] idx,
	input  wire lbkv_pkg::cell_ctrl_t       ctrl,
	input  wire lbkv_pkg::cell_data_t       prev_data,
	input  wire lbkv_pkg::cell_wave_t       prev_wave,
	input  wire lbkv_pkg::cell_data_t       next_data,
	output lbkv_pkg::cell_data_t            data,
	output lbkv_pkg::cell_wave_t            wave
);

	logic                              valid_q;
	logic [lbkv_pkg::KEY_BITS-1:0]     key_q;
	logic [lbkv_pkg::VALUE_BITS-1:0]   value_q;
	logic                              pfx_q;
	logic [lbkv_pkg::VALUE_BITS-1:0]   pass_q;
	logic                              match;
	logic                              head;
	lbkv_pkg::cell_data_t              cur;
	lbkv_pkg::cell_data_t              nxt;

	assign cur   = '{valid: valid_q, key: key_q, value: value_q};
	assign match = valid_q && (key_q == ctrl.key);
	assign head  = (idx == '0);

	always_comb begin
		nxt = cur;
		case (ctrl.mode)
			lbkv_pkg::MODE_HOLD: nxt = cur;
			lbkv_pkg::MODE_FRONT: begin
				if (head) begin
					nxt = '{valid: 1'b1, key: ctrl.key, value: ctrl.value};
				end else if (!prev_wave.pfx) begin
					nxt = prev_data;
				end
			end
			lbkv_pkg::MODE_INSERT: begin
				if (head) begin
					nxt = '{valid: 1'b1, key: ctrl.key, value: ctrl.value};
				end else begin
					nxt       = prev_data;
					nxt.valid = prev_data.valid && (lbkv_pkg::CNT_W'(idx) < ctrl.new_count);
				end
			end
			lbkv_pkg::MODE_REMOVE: begin
				if (pfx_q) begin
					nxt = next_data;
				end
			end
			default: nxt = cur;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pfx_q   <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
			if (ctrl.clr) begin
				pfx_q <= 1'b0;
			end else if (ctrl.scan) begin
				pfx_q <= prev_wave.pfx | match;
			end
		end
	end

	always_ff @(posedge clk) begin
		key_q   <= nxt.key;
		value_q <= nxt.value;
		if (ctrl.scan) begin
			pass_q <= match ? value_q : prev_wave.pass;
		end
	end

	assign data = cur;
	assign wave = '{pfx: pfx_q, pass: pass_q};

endmodule
`default_nettype wire

### rtl/lru_bounded_key_value_table.sv
`timescale 1ns / 1ps
`default_nettype none
// Fixed-capacity key/value table, least recently set entry evicted first.
// Entries sit in a row of cells ordered by age, newest in the first cell.
// A request is taken when start is high and busy is low; busy then stays
// high while the match flag and the matching value ripple one cell per
// cycle down the row in the scan state, then through the apply state in
// which every cell shifts, inserts, drops or holds in parallel. The rsp
// is valid for the single cycle that done is high, as busy falls, and a new
// start may be taken in the same cycle as done. The receiver cannot stall:
// sample rsp while done is high. Capacity is written through cfg_we/cfg_data;
// the user must do so only while the table is idle, which the block does
// not enforce. Values above ENTRIES act as ENTRIES; zero keeps one entry.
module lru_bounded_key_value_table (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire lbkv_pkg::req_t req,
	input  wire logic          cfg_we,
	input  wire logic [4:0]    cfg_data,
	output logic               done,
	output lbkv_pkg::rsp_t     rsp
);

	localparam int N = lbkv_pkg::ENTRIES;

	lbkv_pkg::state_t                 state_q;
	logic [lbkv_pkg::IDX_W-1:0]       scan_cnt_q;
	logic [lbkv_pkg::CNT_W-1:0]       count_q;
	logic [4:0]                       capacity_q;
	lbkv_pkg::req_t                   req_q;
	logic                             done_q;
	lbkv_pkg::rsp_t                   rsp_q;

	lbkv_pkg::cell_ctrl_t             ctrl;
	lbkv_pkg::cell_data_t             cdata [N];
	lbkv_pkg::cell_wave_t             cwave [N];
	lbkv_pkg::cell_data_t             pdata [N];
	lbkv_pkg::cell_wave_t             pwave [N];
	lbkv_pkg::cell_data_t             ndata [N];
	logic [N-1:0]                     valid_vec;

	logic [lbkv_pkg::CNT_W-1:0]       cap;
	logic [lbkv_pkg::CNT_W-1:0]       ev;
	logic [lbkv_pkg::CNT_W-1:0]       new_count;
	logic                             hit;
	logic                             is_set;
	logic                             is_remove;
	logic                             is_lookup;

	assign hit       = cwave[N-1].pfx;
	assign is_set    = (req_q.command == lbkv_pkg::CMD_SET);
	assign is_remove = (req_q.command == lbkv_pkg::CMD_REMOVE);
	assign is_lookup = (req_q.command == lbkv_pkg::CMD_LOOKUP);

	always_comb begin
		cap = (32'(capacity_q) > 32'(N)) ? lbkv_pkg::CNT_W'(N) : lbkv_pkg::CNT_W'(capacity_q);
		if ((count_q != '0) && (count_q >= cap)) begin
			ev = (cap == '0) ? count_q : lbkv_pkg::CNT_W'(count_q - cap + 1'b1);
		end else begin
			ev = '0;
		end
		new_count = lbkv_pkg::CNT_W'(count_q - ev + 1'b1);
	end

	always_comb begin
		ctrl.mode      = lbkv_pkg::MODE_HOLD;
		ctrl.clr       = (state_q == lbkv_pkg::ST_IDLE);
		ctrl.scan      = (state_q == lbkv_pkg::ST_SCAN);
		ctrl.key       = req_q.key[lbkv_pkg::KEY_BITS-1:0];
		ctrl.value     = req_q.new_value[lbkv_pkg::VALUE_BITS-1:0];
		ctrl.new_count = new_count;
		if (state_q == lbkv_pkg::ST_APPLY) begin
			if (is_set) begin
				ctrl.mode = hit ? lbkv_pkg::MODE_FRONT : lbkv_pkg::MODE_INSERT;
			end else if (is_remove && hit) begin
				ctrl.mode = lbkv_pkg::MODE_REMOVE;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign pdata[i] = '0;
			assign pwave[i] = '0;
		end else begin : g_mid
			assign pdata[i] = cdata[i-1];
			assign pwave[i] = cwave[i-1];
		end
		if (i == N - 1) begin : g_last
			assign ndata[i] = '0;
		end else begin : g_inner
			assign ndata[i] = cdata[i+1];
		end
		assign valid_vec[i] = cdata[i].valid;

		lbkv_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (lbkv_pkg::IDX_W'(i)),
			.ctrl      (ctrl),
			.prev_data (pdata[i]),
			.prev_wave (pwave[i]),
			.next_data (ndata[i]),
			.data      (cdata[i]),
			.wave      (cwave[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= lbkv_pkg::ST_IDLE;
			scan_cnt_q <= '0;
			count_q    <= '0;
			capacity_q <= lbkv_pkg::CAPACITY_RESET;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				capacity_q <= cfg_data;
			end
			case (state_q)
				lbkv_pkg::ST_IDLE: begin
					if (start) begin
						scan_cnt_q <= '0;
						state_q    <= lbkv_pkg::ST_SCAN;
					end
				end
				lbkv_pkg::ST_SCAN: begin
					scan_cnt_q <= scan_cnt_q + 1'b1;
					if (scan_cnt_q == lbkv_pkg::IDX_W'(N - 1)) begin
						state_q <= lbkv_pkg::ST_APPLY;
					end
				end
				lbkv_pkg::ST_APPLY: begin
					done_q  <= 1'b1;
					state_q <= lbkv_pkg::ST_IDLE;
					if (is_set && !hit) begin
						count_q <= new_count;
					end else if (is_remove && hit) begin
						count_q <= count_q - 1'b1;
					end
				end
				default: state_q <= lbkv_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == lbkv_pkg::ST_IDLE && start) begin
			req_q <= req;
		end
		if (state_q == lbkv_pkg::ST_APPLY) begin
			rsp_q.found        <= (is_set || is_remove || is_lookup) && hit;
			rsp_q.stored_value <= (is_lookup && hit) ? 64'(cwave[N-1].pass) : 64'd0;
			rsp_q.evictions    <= (is_set && !hit) ? 5'(ev) : 5'd0;
		end
	end

	assign busy = (state_q != lbkv_pkg::ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	a_done_after_apply: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == lbkv_pkg::ST_APPLY))
		else $error("response without apply cycle");

	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lbkv_pkg::ST_IDLE) |-> ($countones(valid_vec) == int'(count_q)))
		else $error("entry count differs from valid cells");

	a_start_enters_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == lbkv_pkg::ST_SCAN))
		else $error("accepted request did not start scan");

	a_evict_only_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (rsp_q.evictions != 5'd0)) |-> !rsp_q.found)
		else $error("eviction reported on a hit");

endmodule
`default_nettype wire
